### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, off while reset is asserted.
`define LPST_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define LPST_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/lpst_pkg.sv
// Types, constants and the UTF-8 encode function of the string transcoder.
package lpst_pkg;

	localparam int MAG_W   = 35;
	localparam int CHARS_W = 14;
	localparam int MAXRES  = 4;

	localparam logic [CHARS_W-1:0] MAX_LENGTH_RST = 14'd10000;

	// Result kinds
	localparam logic [1:0] KIND_TEXT = 2'd0;
	localparam logic [1:0] KIND_DONE = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	typedef enum logic [2:0] {
		PH_HDR0  = 3'd0,
		PH_HDRN  = 3'd1,
		PH_LATIN = 3'd2,
		PH_U16LO = 3'd3,
		PH_U16HI = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       buffer_end;
	} lpst_in_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] kind;
		logic       last;
	} lpst_out_t;

	// All results caused by one request, entry 0 first
	typedef struct packed {
		logic [2:0]                  count;
		lpst_out_t [MAXRES-1:0]      res;
	} lpst_bundle_t;

	typedef struct packed {
		logic [1:0]       len;
		logic [2:0][7:0]  bytes;
	} lpst_char_t;

	// One UTF-16 code unit (or Latin-1 byte) to one to three UTF-8 bytes
	function automatic lpst_char_t utf8_encode(input logic [15:0] ch);
		lpst_char_t c;
		c = '0;
		if (ch < 16'h0080) begin
			c.len      = 2'd1;
			c.bytes[0] = ch[7:0];
		end else if (ch < 16'h0800) begin
			c.len      = 2'd2;
			c.bytes[0] = {3'b110, ch[10:6]};
			c.bytes[1] = {2'b10, ch[5:0]};
		end else begin
			c.len      = 2'd3;
			c.bytes[0] = {4'b1110, ch[15:12]};
			c.bytes[1] = {2'b10, ch[11:6]};
			c.bytes[2] = {2'b10, ch[5:0]};
		end
		return c;
	endfunction

endpackage

### rtl/length_prefixed_string_transcoder.sv
// Top level of the length-prefixed string to UTF-8 transcoder.
// Bytes enter through an input register, are decoded against the header and
// body state, and every result a byte causes (up to four) is loaded at once
// into a result register that drains one result per cycle unless dst_stall
// is high. A byte yielding at most one result is taken every cycle without a
// stall; a byte yielding more holds the output port until all have gone, so
// the input rate follows how many UTF-8 bytes and markers each byte yields.
// max_length may be written only while the block is idle.
module length_prefixed_string_transcoder import lpst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CHARS_W-1:0]  cfg_wr_data,
	input  logic                src_valid,
	output logic                src_stall,
	input  lpst_in_t            src_data,
	output logic                dst_valid,
	input  logic                dst_stall,
	output lpst_out_t           dst_data
);

	logic         bundle_free;
	logic         bundle_load;
	lpst_bundle_t bundle;

	lpst_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.src_valid   (src_valid),
		.src_stall   (src_stall),
		.src_data    (src_data),
		.bundle_free (bundle_free),
		.bundle_load (bundle_load),
		.bundle      (bundle)
	);

	lpst_outbuf u_outbuf (
		.clk         (clk),
		.arst_n      (arst_n),
		.bundle_load (bundle_load),
		.bundle      (bundle),
		.bundle_free (bundle_free),
		.dst_valid   (dst_valid),
		.dst_stall   (dst_stall),
		.dst_data    (dst_data)
	);

endmodule

### rtl/lpst_decode.sv
// Input register, decode state and the per-request result bundle logic.
module lpst_decode import lpst_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [CHARS_W-1:0]  cfg_wr_data,
	input  logic                src_valid,
	output logic                src_stall,
	input  lpst_in_t            src_data,
	input  logic                bundle_free,
	output logic                bundle_load,
	output lpst_bundle_t        bundle
);

	logic               valid_s1;
	lpst_in_t           data_s1;

	logic [CHARS_W-1:0] max_length_q;
	phase_t             phase_q, phase_d;
	logic [2:0]         hdr_idx_q, hdr_idx_d;
	logic [MAG_W-1:0]   mag_q, mag_d;
	logic               neg_q, neg_d;
	logic [CHARS_W-1:0] chars_q, chars_d;
	logic [7:0]         lo_q, lo_d;
	logic               skip_q, skip_d;

	logic               char_en;
	lpst_char_t         enc;
	logic [15:0]        ch;
	logic               mark_en;
	logic [1:0]         mark_kind;
	logic               end_err;
	logic               err;
	logic               hdr_done;
	logic [7:0]         b;
	logic [2:0]         n;
	lpst_out_t [MAXRES-1:0] res;

	assign bundle_load = valid_s1 && bundle_free;
	assign src_stall   = valid_s1 && !bundle_free;
	assign b           = data_s1.in_byte;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (src_valid && !src_stall) begin
			valid_s1 <= 1'b1;
		end else if (bundle_load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			data_s1 <= src_data;
		end
	end

	// Length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RST;
		end else if (cfg_wr_en) begin
			max_length_q <= cfg_wr_data;
		end
	end

	// Decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_HDR0;
			hdr_idx_q <= '0;
			mag_q     <= '0;
			neg_q     <= 1'b0;
			chars_q   <= '0;
			lo_q      <= '0;
			skip_q    <= 1'b0;
		end else if (bundle_load) begin
			phase_q   <= phase_d;
			hdr_idx_q <= hdr_idx_d;
			mag_q     <= mag_d;
			neg_q     <= neg_d;
			chars_q   <= chars_d;
			lo_q      <= lo_d;
			skip_q    <= skip_d;
		end
	end

	// Next state and what this byte emits
	always_comb begin
		phase_d   = phase_q;
		hdr_idx_d = hdr_idx_q;
		mag_d     = mag_q;
		neg_d     = neg_q;
		chars_d   = chars_q;
		lo_d      = lo_q;
		skip_d    = skip_q;
		char_en   = 1'b0;
		ch        = '0;
		mark_en   = 1'b0;
		mark_kind = KIND_DONE;
		end_err   = 1'b0;
		err       = 1'b0;
		hdr_done  = 1'b0;

		if (!skip_q) begin
			unique case (phase_q)
				PH_HDR0: begin
					neg_d = b[7];
					mag_d = MAG_W'(b[5:0]);
					if (b[6]) begin
						hdr_idx_d = 3'd1;
						phase_d   = PH_HDRN;
					end else begin
						hdr_done = 1'b1;
					end
				end
				PH_HDRN: begin
					if (hdr_idx_q >= 3'd4) begin
						mag_d    = mag_q | (MAG_W'(b) << 27);
						hdr_done = 1'b1;
					end else begin
						unique case (hdr_idx_q[1:0])
							2'd1:    mag_d = mag_q | (MAG_W'(b[6:0]) << 6);
							2'd2:    mag_d = mag_q | (MAG_W'(b[6:0]) << 13);
							2'd3:    mag_d = mag_q | (MAG_W'(b[6:0]) << 20);
							default: mag_d = mag_q | (MAG_W'(b[6:0]) << 27);
						endcase
						if (b[7]) begin
							hdr_idx_d = hdr_idx_q + 3'd1;
						end else begin
							hdr_done = 1'b1;
						end
					end
				end
				PH_LATIN: begin
					char_en = !(chars_q == CHARS_W'(1) && b == 8'h00);
					ch      = {8'h00, b};
					chars_d = chars_q - CHARS_W'(1);
					if (chars_d == '0) begin
						mark_en = 1'b1;
						phase_d = PH_HDR0;
					end
				end
				PH_U16LO: begin
					lo_d    = b;
					phase_d = PH_U16HI;
				end
				PH_U16HI: begin
					ch      = {b, lo_q};
					char_en = (ch != 16'h0000);
					chars_d = chars_q - CHARS_W'(1);
					if (chars_d == '0) begin
						mark_en = 1'b1;
						phase_d = PH_HDR0;
					end else begin
						phase_d = PH_U16LO;
					end
				end
				default: begin
					phase_d = PH_HDR0;
				end
			endcase

			// Length index complete: empty string, reject or body start
			if (hdr_done) begin
				hdr_idx_d = '0;
				phase_d   = PH_HDR0;
				if (mag_d == '0) begin
					mark_en = 1'b1;
				end else if (mag_d[MAG_W-1:CHARS_W] != '0 || mag_d[CHARS_W-1:0] > max_length_q) begin
					mark_en   = 1'b1;
					mark_kind = KIND_ERR;
					err       = 1'b1;
					skip_d    = 1'b1;
				end else begin
					chars_d = mag_d[CHARS_W-1:0];
					phase_d = neg_d ? PH_U16LO : PH_LATIN;
				end
				mag_d = '0;
			end
		end

		// Buffer end: flag an unfinished string, then clear decode state
		if (data_s1.buffer_end) begin
			end_err   = !skip_q && !err && (phase_d != PH_HDR0);
			phase_d   = PH_HDR0;
			hdr_idx_d = '0;
			mag_d     = '0;
			neg_d     = 1'b0;
			chars_d   = '0;
			lo_d      = '0;
			skip_d    = 1'b0;
		end
	end

	assign enc = utf8_encode(ch);

	// Pack the results in order: text bytes, end or error marker, buffer end error
	always_comb begin
		n   = '0;
		res = '0;
		if (char_en) begin
			for (int k = 0; k < 3; k++) begin
				if (2'(k) < enc.len) begin
					res[n[1:0]].out_byte = enc.bytes[k];
					res[n[1:0]].kind     = KIND_TEXT;
					n = n + 3'd1;
				end
			end
		end
		if (mark_en && n < 3'd4) begin
			res[n[1:0]].kind = mark_kind;
			n = n + 3'd1;
		end
		if (end_err && n < 3'd4) begin
			res[n[1:0]].kind = KIND_ERR;
			n = n + 3'd1;
		end
		if (n != '0) begin
			res[2'(n - 3'd1)].last = 1'b1;
		end
	end

	assign bundle.count = n;
	assign bundle.res   = res;

endmodule

### rtl/lpst_outbuf.sv
// Result bundle register that hands out one result per cycle while dst_stall is low.
module lpst_outbuf import lpst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         bundle_load,
	input  lpst_bundle_t bundle,
	output logic         bundle_free,
	output logic         dst_valid,
	input  logic         dst_stall,
	output lpst_out_t    dst_data
);

	logic [2:0]             count_s2;
	logic [1:0]             idx_q;
	lpst_out_t [MAXRES-1:0] res_s2;
	logic                   fire;
	logic                   at_last;

	assign dst_valid   = (count_s2 != '0);
	assign dst_data    = res_s2[idx_q];
	assign fire        = dst_valid && !dst_stall;
	assign at_last     = ({1'b0, idx_q} == count_s2 - 3'd1);
	assign bundle_free = !dst_valid || (fire && at_last);

	// Count and read pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_s2 <= '0;
			idx_q    <= '0;
		end else if (bundle_load) begin
			count_s2 <= bundle.count;
			idx_q    <= '0;
		end else if (fire) begin
			if (at_last) begin
				count_s2 <= '0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (bundle_load) begin
			res_s2 <= bundle.res;
		end
	end

endmodule

### rtl/lpst_checker.sv
// Port-level checks on the transcoder, bound to the top level.
`include "assert_macros.svh"

module lpst_checker import lpst_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      dst_valid,
	input logic      dst_stall,
	input lpst_out_t dst_data
);

	// A stalled result holds
	`LPST_ASSERT(a_hold, dst_valid && dst_stall |=> dst_valid && $stable(dst_data), "result changed under stall")
	// Markers close the results of their byte
	`LPST_ASSERT(a_mark_last, dst_valid && dst_data.kind != KIND_TEXT |-> dst_data.last, "marker not last")
	// Markers carry a zero byte and kinds stay in range
	`LPST_ASSERT(a_mark_zero, dst_valid && dst_data.kind != KIND_TEXT |-> dst_data.out_byte == 8'h00 && (dst_data.kind == KIND_DONE || dst_data.kind == KIND_ERR), "bad marker")
	// Nothing is offered while reset is held
	`LPST_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !dst_valid, "result during reset")

endmodule

bind length_prefixed_string_transcoder lpst_checker u_lpst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.dst_valid (dst_valid),
	.dst_stall (dst_stall),
	.dst_data  (dst_data)
);
